@@ rtl/hhc_pkg.sv @@
// shared types, constants and small functions of the heading hemisphere corrector
// no dependencies; used by every module in rtl
package hhc_pkg;

	// angles in radians Q4.12, with headroom for unwrapped sums
	typedef logic signed [19:0] ang_t;

	localparam ang_t PI_Q         = 20'sd12868;
	localparam ang_t TWO_PI_Q     = 20'sd25736;
	localparam ang_t HALF_PI_Q    = 20'sd6434;
	localparam ang_t FIFTH_PI_Q   = 20'sd2574;
	localparam ang_t QUARTER_PI_Q = 20'sd3217;

	localparam logic signed [21:0] PI_Q16 = 22'sd205887;

	// degrees Q9.6 to radians Q4.12 scale, and 1/10 in Q0.16
	localparam logic signed [33:0] DEG_TO_RAD = 34'sd73205;
	localparam logic [12:0]        TENTH_RECIP = 13'd6554;

	// confidence = len8*4096*100 / (133*16*average_speed)
	localparam logic [23:0] CONF_NUM_SCALE = 24'd409600;
	localparam logic [23:0] CONF_DEN_SCALE = 24'd2128;
	localparam logic [12:0] CONF_ONE      = 13'd4096;

	localparam int MAX_STEPS = 9;

	// widths of the shared serial units
	localparam int MUL_W   = 24;
	localparam int PROD_W  = 48;
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;
	localparam int ROOT_W  = 24;
	localparam int CORDIC_STEPS = 16;

	// register index on the configuration port
	localparam logic REG_AVG_SPEED = 1'b0;
	localparam logic [15:0] AVG_SPEED_RESET = 16'd16;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_X, ST_WAIT_X, ST_MUL_Y, ST_WAIT_Y,
		ST_DIV_X, ST_WDIV_X, ST_DIV_Y, ST_WDIV_Y,
		ST_SQ_X, ST_WSQ_X, ST_SQ_Y, ST_WSQ_Y,
		ST_ROOT, ST_WROOT,
		ST_NUM, ST_WNUM, ST_DEN, ST_WDEN,
		ST_DIV_C, ST_WDIV_C,
		ST_ATAN, ST_WATAN,
		ST_FIN1, ST_FIN2, ST_FIN3, ST_FIN4, ST_FIN5, ST_FIN6,
		ST_DONE
	} state_t;

	// step weights 0.9^k in Q1.16
	function automatic logic [16:0] step_weight(input logic [3:0] k);
		logic [16:0] w;
		case (k)
			4'd0: w = 17'd65536;
			4'd1: w = 17'd58982;
			4'd2: w = 17'd53084;
			4'd3: w = 17'd47776;
			4'd4: w = 17'd42998;
			4'd5: w = 17'd38698;
			4'd6: w = 17'd34829;
			4'd7: w = 17'd31346;
			4'd8: w = 17'd28211;
			default: w = 17'd0;
		endcase
		return w;
	endfunction

	// atan(2^-i) in radians Q.16
	function automatic logic [15:0] atan_q16(input logic [3:0] i);
		logic [15:0] a;
		case (i)
			4'd0:  a = 16'd51472;
			4'd1:  a = 16'd30385;
			4'd2:  a = 16'd16055;
			4'd3:  a = 16'd8150;
			4'd4:  a = 16'd4091;
			4'd5:  a = 16'd2047;
			4'd6:  a = 16'd1024;
			4'd7:  a = 16'd512;
			4'd8:  a = 16'd256;
			4'd9:  a = 16'd128;
			4'd10: a = 16'd64;
			4'd11: a = 16'd32;
			4'd12: a = 16'd16;
			4'd13: a = 16'd8;
			4'd14: a = 16'd4;
			default: a = 16'd2;
		endcase
		return a;
	endfunction

	// fold into -pi..pi; inputs stay within a few turns
	function automatic ang_t wrap_pm(input ang_t d);
		ang_t r;
		r = d;
		for (int k = 0; k < 4; k++) begin
			if (r < -PI_Q) r = r + TWO_PI_Q;
			else if (r > PI_Q) r = r - TWO_PI_Q;
		end
		return r;
	endfunction

	// fold into 0..2pi
	function automatic ang_t wrap_pos(input ang_t a);
		ang_t r;
		r = a;
		for (int k = 0; k < 4; k++) begin
			if (r > TWO_PI_Q) r = r - TWO_PI_Q;
			else if (r < 0) r = r + TWO_PI_Q;
		end
		return r;
	endfunction

endpackage

@@ rtl/hhc_serial_mul.sv @@
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// depends on hhc_pkg
module hhc_serial_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hhc_pkg::MUL_W-1:0]         a,
	input  logic [hhc_pkg::MUL_W-1:0]         b,
	output logic                              done,
	output logic [hhc_pkg::PROD_W-1:0]        product
);

	logic                              busy_q;
	logic                              done_q;
	logic [4:0]                        cnt_q;
	logic [hhc_pkg::PROD_W-1:0]        acc_q;
	logic [hhc_pkg::PROD_W-1:0]        a_q;
	logic [hhc_pkg::MUL_W-1:0]         b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(hhc_pkg::MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= hhc_pkg::PROD_W'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ rtl/hhc_serial_div.sv @@
// restoring divider, one quotient bit per cycle, floor quotient
// depends on hhc_pkg
module hhc_serial_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hhc_pkg::DIV_N_W-1:0]       numer,
	input  logic [hhc_pkg::DIV_D_W-1:0]       denom,
	output logic                              done,
	output logic [hhc_pkg::DIV_N_W-1:0]       quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [5:0]                        cnt_q;
	logic [hhc_pkg::DIV_N_W-1:0]       quo_q;
	logic [hhc_pkg::DIV_D_W-1:0]       rem_q;
	logic [hhc_pkg::DIV_D_W-1:0]       den_q;
	logic [hhc_pkg::DIV_D_W:0]         trial;
	logic [hhc_pkg::DIV_D_W:0]         diff;
	logic                              fits;

	always_comb begin
		trial = {rem_q, quo_q[hhc_pkg::DIV_N_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(hhc_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= fits ? diff[hhc_pkg::DIV_D_W-1:0] : trial[hhc_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[hhc_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/hhc_isqrt.sv @@
// floor square root, one result bit (two radicand bits) per cycle
// depends on hhc_pkg
module hhc_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hhc_pkg::PROD_W-1:0]        radicand,
	output logic                              done,
	output logic [hhc_pkg::ROOT_W-1:0]        root
);

	logic                              busy_q;
	logic                              done_q;
	logic [4:0]                        cnt_q;
	logic [hhc_pkg::PROD_W-1:0]        v_q;
	logic [hhc_pkg::PROD_W-1:0]        r_q;
	logic [hhc_pkg::PROD_W-1:0]        bit_q;
	logic [hhc_pkg::PROD_W-1:0]        trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(hhc_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= hhc_pkg::PROD_W'(1) << (hhc_pkg::PROD_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[hhc_pkg::ROOT_W-1:0];

endmodule

@@ rtl/hhc_cordic.sv @@
// vectoring cordic, one micro-rotation per cycle, angle out in radians Q4.12
// depends on hhc_pkg
module hhc_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [21:0]  x_in,
	input  logic signed [21:0]  y_in,
	output logic                done,
	output logic signed [15:0]  angle
);

	logic                busy_q;
	logic                done_q;
	logic [3:0]          cnt_q;
	logic signed [32:0]  x_q;
	logic signed [32:0]  y_q;
	logic signed [21:0]  z_q;
	logic signed [21:0]  base_q;
	logic signed [32:0]  xs;
	logic signed [32:0]  ys;
	logic signed [21:0]  step;
	logic signed [21:0]  total;
	logic                null_vec;

	assign null_vec = (x_in == 22'sd0) && (y_in == 22'sd0);
	assign xs    = x_q >>> cnt_q;
	assign ys    = y_q >>> cnt_q;
	assign step  = 22'(hhc_pkg::atan_q16(cnt_q));
	assign total = (base_q + z_q + 22'sd8) >>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (null_vec) done_q <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(hhc_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			z_q <= '0;
			// left half plane: turn by half a revolution first
			if (x_in < 0) begin
				base_q <= (y_in >= 0) ? hhc_pkg::PI_Q16 : -hhc_pkg::PI_Q16;
				x_q    <= (-33'(x_in)) <<< 8;
				y_q    <= (-33'(y_in)) <<< 8;
			end else begin
				base_q <= '0;
				x_q    <= 33'(x_in) <<< 8;
				y_q    <= 33'(y_in) <<< 8;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step;
			end
		end
	end

	assign done  = done_q;
	assign angle = total[15:0];

endmodule

@@ rtl/heading_hemisphere_corrector_core.sv @@
// Heading corrector for one tracked object per request. Position history is kept in a
// shift register; the movement heading runs through shared bit-serial units (multiplier,
// divider, square root, cordic). A request with a usable history spends most of its time
// on two serial multiplies per history step over up to nine steps, plus
// three serial divisions; a request without history skips the serial units.
// Depends on hhc_pkg, hhc_serial_mul, hhc_serial_div, hhc_isqrt, hhc_cordic.
module heading_hemisphere_corrector_core #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// pos_x[15:0], pos_y[31:16], measured_angle[47:32], prior_angle[63:48]
	input  logic [63:0] s_axis_tdata,
	// pos_valid[0], measured_present[1], prior_valid[2]
	input  logic [2:0]  s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// corrected_angle[14:0], heading_confidence[27:15], zero fill above
	output logic [31:0] m_axis_tdata,
	// angle_written[0], confident[1], history_valid[2]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W  = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SW     = (FILL_W > 4) ? FILL_W : 4;

	hhc_pkg::state_t state_q, state_d;

	// request capture
	logic [15:0]        px_q, py_q;
	logic               pv_q, mp_q, prv_q, hok_q;
	logic signed [15:0] meas_q, prior_q;

	// history state
	logic [31:0]        hist_q [HISTORY_DEPTH];
	logic [FILL_W-1:0]  fill_q;
	logic [1:0]         frames_q;
	logic [1:0]         recent_q;
	logic [15:0]        avg_q;

	// movement datapath
	logic [IDX_W-1:0]   idx_q;
	logic [SW-1:0]      steps_q;
	logic [15:0]        nx_q, ny_q;
	logic signed [39:0] sxs_q, sys_q;
	logic [18:0]        wsum_q;
	logic signed [20:0] dx8_q, dy8_q;
	logic [47:0]        sq_q;
	logic [23:0]        len_q;
	logic [47:0]        num_q;
	logic [31:0]        den_q;
	logic [12:0]        conf_q;
	hhc_pkg::ang_t      hang_q, prop_q, dev_q, res_q;
	logic signed [33:0] prod_q;
	logic               cflag_q;

	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic [2:0]         m_tuser_q;

	// unit controls
	logic               mul_start, div_start, root_start, atan_start;
	logic [23:0]        mul_a, mul_b;
	logic [47:0]        div_n;
	logic [31:0]        div_d;
	logic               mul_done, div_done, root_done, atan_done;
	logic [47:0]        mul_p, div_q;
	logic [23:0]        root_r;
	logic signed [15:0] atan_r;
	logic               out_load;

	// input fields
	logic               in_pv, in_prv, hok_in, accept;
	logic [SW-1:0]      fill_ext;

	// step and finishing wires
	logic [31:0]        cur;
	logic signed [16:0] diff_x, diff_y;
	logic [15:0]        adx, ady;
	logic [16:0]        w_cur;
	logic [39:0]        sxs_mag, sys_mag;
	logic [19:0]        dx8_mag, dy8_mag;
	logic [20:0]        qn;
	logic               last_step;
	hhc_pkg::ang_t      comp, pose, d2, dev3, dev10, d6;
	logic [13:0]        dmag;
	logic [26:0]        tprod;
	logic               far, big;

	assign in_pv  = s_axis_tuser[0];
	assign in_prv = s_axis_tuser[2];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign hok_in = (frames_q == 2'd3) && in_pv && (recent_q == 2'b11) && (fill_q != '0);
	assign fill_ext = SW'(fill_q);

	assign cur    = hist_q[idx_q];
	assign diff_x = $signed({1'b0, nx_q}) - $signed({1'b0, cur[31:16]});
	assign diff_y = $signed({1'b0, ny_q}) - $signed({1'b0, cur[15:0]});
	assign adx    = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
	assign ady    = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];
	assign w_cur  = hhc_pkg::step_weight(4'(idx_q));
	assign last_step = (SW'(idx_q) + SW'(1)) == steps_q;

	assign sxs_mag = sxs_q[39] ? 40'(-sxs_q) : 40'(sxs_q);
	assign sys_mag = sys_q[39] ? 40'(-sys_q) : 40'(sys_q);
	assign dx8_mag = dx8_q[20] ? 20'(-dx8_q) : dx8_q[19:0];
	assign dy8_mag = dy8_q[20] ? 20'(-dy8_q) : dy8_q[19:0];
	assign qn      = div_q[20:0];

	assign comp = hok_q ? hang_q : hhc_pkg::ang_t'(prior_q);
	assign pose = 20'((prod_q + 34'sd32768) >>> 16);
	assign d2   = hhc_pkg::wrap_pm(pose - comp);
	assign far  = (d2 > hhc_pkg::HALF_PI_Q) || (d2 < -hhc_pkg::HALF_PI_Q);
	assign dev3 = hhc_pkg::wrap_pm(hhc_pkg::ang_t'(prior_q) - prop_q);
	assign big  = (dev_q > hhc_pkg::FIFTH_PI_Q) || (dev_q < -hhc_pkg::FIFTH_PI_Q);
	assign dmag = dev_q[19] ? 14'(-dev_q) : dev_q[13:0];
	// divide by ten through the reciprocal, exact for this range
	assign tprod = 27'(dmag) * 27'(hhc_pkg::TENTH_RECIP);
	assign dev10 = dev_q[19] ? -hhc_pkg::ang_t'({9'd0, tprod[26:16]})
	                         : hhc_pkg::ang_t'({9'd0, tprod[26:16]});
	assign d6   = hhc_pkg::wrap_pm(res_q - hang_q);

	hhc_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .product(mul_p)
	);

	hhc_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(div_n), .denom(div_d),
		.done(div_done), .quotient(div_q)
	);

	hhc_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(root_start), .radicand(sq_q),
		.done(root_done), .root(root_r)
	);

	hhc_cordic u_atan (
		.clk(clk), .arst_n(arst_n), .start(atan_start),
		.x_in({dx8_q[20], dx8_q}), .y_in(-{dy8_q[20], dy8_q}),
		.done(atan_done), .angle(atan_r)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hhc_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (hok_in) state_d = hhc_pkg::ST_MUL_X;
					else if (in_prv) state_d = hhc_pkg::ST_FIN1;
					else state_d = hhc_pkg::ST_DONE;
				end
			end
			hhc_pkg::ST_MUL_X:  state_d = hhc_pkg::ST_WAIT_X;
			hhc_pkg::ST_WAIT_X: if (mul_done) state_d = hhc_pkg::ST_MUL_Y;
			hhc_pkg::ST_MUL_Y:  state_d = hhc_pkg::ST_WAIT_Y;
			hhc_pkg::ST_WAIT_Y: begin
				if (mul_done) state_d = last_step ? hhc_pkg::ST_DIV_X : hhc_pkg::ST_MUL_X;
			end
			hhc_pkg::ST_DIV_X:  state_d = hhc_pkg::ST_WDIV_X;
			hhc_pkg::ST_WDIV_X: if (div_done) state_d = hhc_pkg::ST_DIV_Y;
			hhc_pkg::ST_DIV_Y:  state_d = hhc_pkg::ST_WDIV_Y;
			hhc_pkg::ST_WDIV_Y: if (div_done) state_d = hhc_pkg::ST_SQ_X;
			hhc_pkg::ST_SQ_X:   state_d = hhc_pkg::ST_WSQ_X;
			hhc_pkg::ST_WSQ_X:  if (mul_done) state_d = hhc_pkg::ST_SQ_Y;
			hhc_pkg::ST_SQ_Y:   state_d = hhc_pkg::ST_WSQ_Y;
			hhc_pkg::ST_WSQ_Y:  if (mul_done) state_d = hhc_pkg::ST_ROOT;
			hhc_pkg::ST_ROOT:   state_d = hhc_pkg::ST_WROOT;
			hhc_pkg::ST_WROOT:  if (root_done) state_d = hhc_pkg::ST_NUM;
			hhc_pkg::ST_NUM:    state_d = hhc_pkg::ST_WNUM;
			hhc_pkg::ST_WNUM:   if (mul_done) state_d = hhc_pkg::ST_DEN;
			hhc_pkg::ST_DEN:    state_d = hhc_pkg::ST_WDEN;
			hhc_pkg::ST_WDEN:   if (mul_done) state_d = hhc_pkg::ST_DIV_C;
			hhc_pkg::ST_DIV_C:  state_d = hhc_pkg::ST_WDIV_C;
			hhc_pkg::ST_WDIV_C: if (div_done) state_d = hhc_pkg::ST_ATAN;
			hhc_pkg::ST_ATAN:   state_d = hhc_pkg::ST_WATAN;
			hhc_pkg::ST_WATAN:  if (atan_done) state_d = hhc_pkg::ST_FIN1;
			hhc_pkg::ST_FIN1:   state_d = mp_q ? hhc_pkg::ST_FIN2 : hhc_pkg::ST_FIN5;
			hhc_pkg::ST_FIN2:   state_d = hhc_pkg::ST_FIN3;
			hhc_pkg::ST_FIN3:   state_d = hhc_pkg::ST_FIN4;
			hhc_pkg::ST_FIN4:   state_d = hhc_pkg::ST_FIN5;
			hhc_pkg::ST_FIN5:   state_d = mp_q ? hhc_pkg::ST_FIN6 : hhc_pkg::ST_DONE;
			hhc_pkg::ST_FIN6:   state_d = hhc_pkg::ST_DONE;
			hhc_pkg::ST_DONE:   if (out_load) state_d = hhc_pkg::ST_IDLE;
			default:            state_d = hhc_pkg::ST_IDLE;
		endcase
	end

	// unit launches and operand selection
	always_comb begin
		s_axis_tready = (state_q == hhc_pkg::ST_IDLE);
		out_load   = (state_q == hhc_pkg::ST_DONE) && (!m_tvalid_q || m_axis_tready);
		mul_start  = 1'b0;
		div_start  = 1'b0;
		root_start = 1'b0;
		atan_start = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_n      = '0;
		div_d      = '0;
		unique case (state_q)
			hhc_pkg::ST_MUL_X: begin
				mul_start = 1'b1;
				mul_a     = 24'(w_cur);
				mul_b     = 24'(adx);
			end
			hhc_pkg::ST_MUL_Y: begin
				mul_start = 1'b1;
				mul_a     = 24'(w_cur);
				mul_b     = 24'(ady);
			end
			hhc_pkg::ST_DIV_X: begin
				// rounded: add half the weight sum before the floor division
				div_start = 1'b1;
				div_n     = (48'(sxs_mag) << 4) + 48'(wsum_q >> 1);
				div_d     = 32'(wsum_q);
			end
			hhc_pkg::ST_DIV_Y: begin
				div_start = 1'b1;
				div_n     = (48'(sys_mag) << 4) + 48'(wsum_q >> 1);
				div_d     = 32'(wsum_q);
			end
			hhc_pkg::ST_SQ_X: begin
				mul_start = 1'b1;
				mul_a     = 24'(dx8_mag);
				mul_b     = 24'(dx8_mag);
			end
			hhc_pkg::ST_SQ_Y: begin
				mul_start = 1'b1;
				mul_a     = 24'(dy8_mag);
				mul_b     = 24'(dy8_mag);
			end
			hhc_pkg::ST_ROOT: root_start = 1'b1;
			hhc_pkg::ST_NUM: begin
				mul_start = 1'b1;
				mul_a     = len_q;
				mul_b     = hhc_pkg::CONF_NUM_SCALE;
			end
			hhc_pkg::ST_DEN: begin
				mul_start = 1'b1;
				mul_a     = 24'(avg_q);
				mul_b     = hhc_pkg::CONF_DEN_SCALE;
			end
			hhc_pkg::ST_DIV_C: begin
				div_start = 1'b1;
				div_n     = num_q;
				div_d     = den_q;
			end
			hhc_pkg::ST_ATAN: atan_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hhc_pkg::ST_IDLE;
			fill_q     <= '0;
			frames_q   <= '0;
			recent_q   <= '0;
			avg_q      <= hhc_pkg::AVG_SPEED_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && (paddr[2] == hhc_pkg::REG_AVG_SPEED)) begin
				avg_q <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				if (pv_q && (fill_q < FILL_W'(HISTORY_DEPTH))) fill_q <= fill_q + FILL_W'(1);
				recent_q <= {recent_q[0], pv_q};
				if (frames_q != 2'd3) frames_q <= frames_q + 2'd1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// history shift line
	always_ff @(posedge clk) begin
		if (out_load && pv_q) begin
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_q[i] <= hist_q[i - 1];
			hist_q[0] <= {px_q, py_q};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'd0, conf_q, res_q[14:0]};
			m_tuser_q <= {hok_q, cflag_q, hok_q || prv_q};
		end
		unique case (state_q)
			hhc_pkg::ST_IDLE: begin
				if (accept) begin
					px_q    <= s_axis_tdata[15:0];
					py_q    <= s_axis_tdata[31:16];
					meas_q  <= s_axis_tdata[47:32];
					prior_q <= s_axis_tdata[63:48];
					pv_q    <= in_pv;
					mp_q    <= s_axis_tuser[1];
					prv_q   <= in_prv;
					hok_q   <= hok_in;
					nx_q    <= s_axis_tdata[15:0];
					ny_q    <= s_axis_tdata[31:16];
					idx_q   <= '0;
					steps_q <= (fill_ext < SW'(hhc_pkg::MAX_STEPS)) ? fill_ext
					                                                : SW'(hhc_pkg::MAX_STEPS);
					sxs_q   <= '0;
					sys_q   <= '0;
					wsum_q  <= '0;
					hang_q  <= '0;
					conf_q  <= '0;
					res_q   <= '0;
					cflag_q <= 1'b0;
				end
			end
			hhc_pkg::ST_WAIT_X: begin
				if (mul_done) begin
					sxs_q <= diff_x[16] ? sxs_q - $signed(mul_p[39:0])
					                    : sxs_q + $signed(mul_p[39:0]);
				end
			end
			hhc_pkg::ST_WAIT_Y: begin
				if (mul_done) begin
					sys_q  <= diff_y[16] ? sys_q - $signed(mul_p[39:0])
					                     : sys_q + $signed(mul_p[39:0]);
					wsum_q <= wsum_q + 19'(w_cur);
					nx_q   <= cur[31:16];
					ny_q   <= cur[15:0];
					if (!last_step) idx_q <= idx_q + IDX_W'(1);
				end
			end
			hhc_pkg::ST_WDIV_X: if (div_done) dx8_q <= sxs_q[39] ? (~qn + 21'd1) : qn;
			hhc_pkg::ST_WDIV_Y: if (div_done) dy8_q <= sys_q[39] ? (~qn + 21'd1) : qn;
			hhc_pkg::ST_WSQ_X:  if (mul_done) sq_q <= mul_p;
			hhc_pkg::ST_WSQ_Y:  if (mul_done) sq_q <= sq_q + mul_p;
			hhc_pkg::ST_WROOT:  if (root_done) len_q <= root_r;
			hhc_pkg::ST_WNUM:   if (mul_done) num_q <= mul_p;
			hhc_pkg::ST_WDEN:   if (mul_done) den_q <= mul_p[31:0];
			hhc_pkg::ST_WDIV_C: begin
				if (div_done) begin
					conf_q <= (div_q > 48'(hhc_pkg::CONF_ONE)) ? hhc_pkg::CONF_ONE : div_q[12:0];
				end
			end
			hhc_pkg::ST_WATAN:  if (atan_done) hang_q <= hhc_pkg::ang_t'(atan_r);
			hhc_pkg::ST_FIN1: begin
				prod_q <= 34'(meas_q) * hhc_pkg::DEG_TO_RAD;
				prop_q <= comp;
			end
			hhc_pkg::ST_FIN2: begin
				// mirror the measurement into the hemisphere of the reference heading
				prop_q <= far ? pose + hhc_pkg::PI_Q : pose;
			end
			hhc_pkg::ST_FIN3: begin
				if (!prv_q) prop_q <= hang_q;
				dev_q <= dev3;
			end
			hhc_pkg::ST_FIN4: begin
				if (prv_q && big) begin
					prop_q <= (meas_q == 16'sd0) ? hhc_pkg::ang_t'(prior_q)
					                             : hhc_pkg::ang_t'(prior_q) - dev10;
				end
			end
			hhc_pkg::ST_FIN5:   res_q <= hhc_pkg::wrap_pos(prop_q);
			hhc_pkg::ST_FIN6: begin
				cflag_q <= prv_q || ((d6 < hhc_pkg::QUARTER_PI_Q) &&
				                     (d6 > -hhc_pkg::QUARTER_PI_Q));
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == hhc_pkg::REG_AVG_SPEED) ? {16'd0, avg_q} : 32'd0;

endmodule
